/* rtl/ptt_pkg.sv */
// ptt_pkg: shared types and codes of the periodic timer table
// used by ptt_cell, ptt_ctrl and periodic_timer_table; no dependencies

package ptt_pkg;

	localparam int IdW   = 16;
	localparam int TimeW = 31;
	localparam int KindW = 3;

	// request kinds
	localparam logic [KindW-1:0] KIND_TICK   = 3'd0;
	localparam logic [KindW-1:0] KIND_ADD    = 3'd1;
	localparam logic [KindW-1:0] KIND_PAUSE  = 3'd2;
	localparam logic [KindW-1:0] KIND_RESUME = 3'd3;
	localparam logic [KindW-1:0] KIND_DELETE = 3'd4;
	localparam logic [KindW-1:0] KIND_CHANGE = 3'd5;

	// result status codes
	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND   = 2'd1;
	localparam logic [1:0] STAT_BELOW_TICK  = 2'd2;
	localparam logic [1:0] STAT_FULL        = 2'd3;

	localparam logic [IdW-1:0] ID_FIRST = 16'd1;
	localparam logic [IdW-1:0] ID_LAST  = 16'hFFFF;

	typedef struct packed {
		logic             valid;
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] period;
		logic [TimeW-1:0] count;
		logic             paused;
	} entry_t;

	// request broadcast to every cell
	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] ticks;
		logic             ticks_zero;
		logic [IdW-1:0]   new_id;
	} cmd_t;

	// chain status back to the controller
	typedef struct packed {
		logic           last_tok;
		logic           found;
		logic           fire;
		logic [IdW-1:0] fire_id;
	} scan_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

/* rtl/ptt_cell.sv */
// ptt_cell: one table slot with its share of the scan token
// depends on ptt_pkg

module ptt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_in,
	input  logic            fnd_in,
	input  ptt_pkg::entry_t nbr,
	input  ptt_pkg::cmd_t   cmd,
	output logic            tok,
	output logic            fnd_next,
	output ptt_pkg::entry_t ent,
	output logic            fire
);

	ptt_pkg::entry_t ent_q;
	ptt_pkg::entry_t ent_d;
	logic            tok_q;
	logic            fnd_q;
	logic            hit;
	logic            match;
	logic [ptt_pkg::TimeW-1:0] cnt_inc;

	// first valid slot holding the addressed id, nothing found earlier
	assign match   = ent_q.valid && !fnd_q && (ent_q.id == cmd.id);
	assign cnt_inc = ent_q.count + 31'd1;

	always_comb begin
		hit   = 1'b0;
		fire  = 1'b0;
		ent_d = ent_q;
		if (tok_q) begin
			unique case (cmd.kind)
				ptt_pkg::KIND_TICK: begin
					if (ent_q.valid && !ent_q.paused) begin
						if (cnt_inc >= ent_q.period) begin
							fire        = 1'b1;
							ent_d.count = '0;
						end else begin
							ent_d.count = cnt_inc;
						end
					end
				end
				ptt_pkg::KIND_ADD: begin
					if (!ent_q.valid && !fnd_q && !cmd.ticks_zero) begin
						hit          = 1'b1;
						ent_d.valid  = 1'b1;
						ent_d.id     = cmd.new_id;
						ent_d.period = cmd.ticks;
						ent_d.count  = '0;
						ent_d.paused = 1'b0;
					end
				end
				ptt_pkg::KIND_PAUSE: begin
					if (match) begin
						hit          = 1'b1;
						ent_d.paused = 1'b1;
					end
				end
				ptt_pkg::KIND_RESUME: begin
					if (match) begin
						hit          = 1'b1;
						ent_d.paused = 1'b0;
					end
				end
				ptt_pkg::KIND_DELETE: begin
					hit = match;
					// from the deleted slot on, take the upper neighbor
					if (fnd_q || match) begin
						ent_d = nbr;
					end
				end
				ptt_pkg::KIND_CHANGE: begin
					if (match) begin
						hit = 1'b1;
						if (!cmd.ticks_zero) begin
							ent_d.period = cmd.ticks;
							ent_d.count  = '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
			tok_q <= 1'b0;
			fnd_q <= 1'b0;
		end else begin
			ent_q <= ent_d;
			tok_q <= tok_in;
			fnd_q <= fnd_in;
		end
	end

	assign tok      = tok_q;
	assign fnd_next = fnd_q | hit;
	assign ent      = ent_q;

endmodule

/* rtl/ptt_ctrl.sv */
// ptt_ctrl: request capture, period to tick conversion, scan sequencing, results
// depends on ptt_pkg

module ptt_ctrl #(
	parameter int TICK_TIME = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ptt_pkg::KindW-1:0]  kind,
	input  logic [ptt_pkg::IdW-1:0]    timer_id,
	input  logic [ptt_pkg::TimeW-1:0]  period_time,
	input  ptt_pkg::scan_t             scan,
	output ptt_pkg::cmd_t              cmd,
	output logic                       tok_inject,
	output logic                       busy,
	output logic                       result_valid,
	output logic [1:0]                 status,
	output logic [ptt_pkg::IdW-1:0]    new_id,
	output logic                       fired,
	output logic [ptt_pkg::IdW-1:0]    fired_id,
	output logic                       last
);

	// exact division by a constant: ceil(2^SHIFT / TICK_TIME), at most 32 bits
	localparam int          SHIFT  = ptt_pkg::TimeW + $clog2(TICK_TIME);
	localparam logic [63:0] RECIP  = ((64'd1 << SHIFT) + 64'(TICK_TIME) - 64'd1)
		/ 64'(TICK_TIME);
	localparam logic [31:0] RECIP_W = RECIP[31:0];

	ptt_pkg::state_t state_q, state_d;

	logic                      accept;
	logic [ptt_pkg::KindW-1:0] kind_q;
	logic [ptt_pkg::IdW-1:0]   id_q;
	logic [62:0]               prod_q;
	logic [62:0]               quo;
	logic [ptt_pkg::IdW-1:0]   next_id_q;
	logic                      found_q;
	logic                      pend_q;
	logic [ptt_pkg::IdW-1:0]   pend_id_q;

	logic                      res_valid_d;
	logic [1:0]                status_d;
	logic [ptt_pkg::IdW-1:0]   new_id_d;
	logic                      fired_d;
	logic [ptt_pkg::IdW-1:0]   fired_id_d;
	logic                      last_d;
	logic                      bump_id;

	logic                      result_valid_q;
	logic [1:0]                status_q;
	logic [ptt_pkg::IdW-1:0]   new_id_q;
	logic                      fired_q;
	logic [ptt_pkg::IdW-1:0]   fired_id_q;
	logic                      last_q;

	assign busy       = (state_q == ptt_pkg::S_SCAN);
	assign accept     = start && !busy;
	assign tok_inject = accept;

	assign quo            = prod_q >> SHIFT;
	assign cmd.kind       = kind_q;
	assign cmd.id         = id_q;
	assign cmd.ticks      = quo[ptt_pkg::TimeW-1:0];
	assign cmd.ticks_zero = (quo[ptt_pkg::TimeW-1:0] == '0);
	assign cmd.new_id     = next_id_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptt_pkg::S_IDLE: if (accept) state_d = ptt_pkg::S_SCAN;
			ptt_pkg::S_SCAN: if (scan.last_tok) state_d = ptt_pkg::S_DONE;
			ptt_pkg::S_DONE: begin
				state_d = accept ? ptt_pkg::S_SCAN : ptt_pkg::S_IDLE;
			end
			default: state_d = ptt_pkg::S_IDLE;
		endcase
	end

	// results
	always_comb begin
		res_valid_d = 1'b0;
		status_d    = ptt_pkg::STAT_OK;
		new_id_d    = '0;
		fired_d     = 1'b0;
		fired_id_d  = '0;
		last_d      = 1'b0;
		bump_id     = 1'b0;
		unique case (state_q)
			ptt_pkg::S_SCAN: begin
				// a newer fire proves the held one is not the last
				if (scan.fire && pend_q) begin
					res_valid_d = 1'b1;
					fired_d     = 1'b1;
					fired_id_d  = pend_id_q;
				end
			end
			ptt_pkg::S_DONE: begin
				res_valid_d = 1'b1;
				last_d      = 1'b1;
				unique case (kind_q) inside
					ptt_pkg::KIND_TICK: begin
						fired_d    = pend_q;
						fired_id_d = pend_q ? pend_id_q : '0;
					end
					ptt_pkg::KIND_ADD: begin
						if (cmd.ticks_zero) begin
							status_d = ptt_pkg::STAT_BELOW_TICK;
						end else if (found_q) begin
							new_id_d = next_id_q;
							bump_id  = 1'b1;
						end else begin
							status_d = ptt_pkg::STAT_FULL;
						end
					end
					ptt_pkg::KIND_PAUSE, ptt_pkg::KIND_RESUME,
					ptt_pkg::KIND_DELETE, ptt_pkg::KIND_CHANGE: begin
						status_d = found_q ? ptt_pkg::STAT_OK : ptt_pkg::STAT_NOT_FOUND;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ptt_pkg::S_IDLE;
			next_id_q      <= ptt_pkg::ID_FIRST;
			found_q        <= 1'b0;
			pend_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= res_valid_d;
			if (bump_id) begin
				next_id_q <= (next_id_q == ptt_pkg::ID_LAST) ? ptt_pkg::ID_FIRST
					: next_id_q + 16'd1;
			end
			if (busy && scan.last_tok) begin
				found_q <= scan.found;
			end
			if (accept) begin
				pend_q <= 1'b0;
			end else if (busy && scan.fire) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			id_q   <= timer_id;
			prod_q <= 63'(period_time) * 63'(RECIP_W);
		end
		if (busy && scan.fire) begin
			pend_id_q <= scan.fire_id;
		end
		status_q   <= status_d;
		new_id_q   <= new_id_d;
		fired_q    <= fired_d;
		fired_id_q <= fired_id_d;
		last_q     <= last_d;
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign new_id       = new_id_q;
	assign fired        = fired_q;
	assign fired_id     = fired_id_q;
	assign last         = last_q;

endmodule

/* rtl/periodic_timer_table.sv */
// periodic_timer_table: top level, a row of ENTRIES timer cells and the controller
// depends on ptt_pkg, ptt_cell, ptt_ctrl

// A table of up to ENTRIES periodic timers kept in add order, one timer per
// cell. A request is taken when start is high and busy is low. Every request
// runs a token once along the row of cells, one cell per cycle, so busy is
// high while the token travels the row; the request results come out with
// result_valid high for one cycle each, the final one marked by last, and a
// new request can be taken as soon as busy falls. The receiver cannot stall:
// results must be taken the cycle they appear. A tick gives one result per
// expired timer in table order (delayed by one hit so the last one can be
// flagged), or one empty result if none expired. The requested period is
// turned into ticks by an exact reciprocal multiply by 1/TICK_TIME, registered
// as the request is taken. Delete closes the gap by having every cell from the
// deleted one upward take its upper neighbor as the token passes.

module periodic_timer_table #(
	parameter int ENTRIES   = 8,
	parameter int TICK_TIME = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ptt_pkg::KindW-1:0] kind,
	input  logic [ptt_pkg::IdW-1:0]   timer_id,
	input  logic [ptt_pkg::TimeW-1:0] period_time,
	output logic                      result_valid,
	output logic [1:0]                status,
	output logic [ptt_pkg::IdW-1:0]   new_id,
	output logic                      fired,
	output logic [ptt_pkg::IdW-1:0]   fired_id,
	output logic                      last
);

	// token and found flag between cells: node i feeds cell i, node i+1 leaves it
	logic [ENTRIES:0]   tok_c;
	logic [ENTRIES:0]   fnd_c;
	// stored entries, plus an empty one past the top cell for delete
	ptt_pkg::entry_t    ent_c [ENTRIES+1];
	logic [ENTRIES-1:0] fire_c;

	ptt_pkg::cmd_t  cmd;
	ptt_pkg::scan_t scan;
	logic           tok_inject;
	logic [ptt_pkg::IdW-1:0] fire_id;

	assign tok_c[0]       = tok_inject;
	assign fnd_c[0]       = 1'b0;
	assign ent_c[ENTRIES] = '0;

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			ptt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.tok_in   (tok_c[gi]),
				.fnd_in   (fnd_c[gi]),
				.nbr      (ent_c[gi+1]),
				.cmd      (cmd),
				.tok      (tok_c[gi+1]),
				.fnd_next (fnd_c[gi+1]),
				.ent      (ent_c[gi]),
				.fire     (fire_c[gi])
			);
		end
	endgenerate

	// only the cell holding the token can fire
	always_comb begin
		fire_id = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (fire_c[i]) begin
				fire_id = fire_id | ent_c[i].id;
			end
		end
	end

	assign scan.last_tok = tok_c[ENTRIES];
	assign scan.found    = fnd_c[ENTRIES];
	assign scan.fire     = |fire_c;
	assign scan.fire_id  = fire_id;

	ptt_ctrl #(
		.TICK_TIME (TICK_TIME)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (kind),
		.timer_id     (timer_id),
		.period_time  (period_time),
		.scan         (scan),
		.cmd          (cmd),
		.tok_inject   (tok_inject),
		.busy         (busy),
		.result_valid (result_valid),
		.status       (status),
		.new_id       (new_id),
		.fired        (fired),
		.fired_id     (fired_id),
		.last         (last)
	);

	// never more than one cell holds the token
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_c[ENTRIES:1]))
		else $error("more than one cell holds the scan token");

	// a taken request starts a scan
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken without starting a scan");

	// the end of a scan is followed by the final result of the request
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |=> result_valid && last)
		else $error("scan ended without a final result");

	// an expiry report never carries an add outcome
	a_fire_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fired |-> status == ptt_pkg::STAT_OK && new_id == '0)
		else $error("expiry result with add fields set");

endmodule
